// ===== src/tvd_pkg.sv =====
// Shared constants, types and codes for the tolerant vertex dedup block.
// No dependencies; every other file but tvd_ram refers to it by scoped names.
`timescale 1ns / 1ps

package tvd_pkg;

  localparam int unsigned MAX_VERTICES = 1024;
  localparam int unsigned NFIELDS      = 8;
  localparam int unsigned FIELD_W      = 32;
  localparam int unsigned ENTRY_W      = NFIELDS * FIELD_W;
  localparam int unsigned IDX_W        = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int unsigned VIDX_W       = 10;
  localparam int unsigned TOL_W        = 31;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(655);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(MAX_VERTICES);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic miss;
    logic slot_free;
  } status_t;

  typedef struct packed {
    logic [VIDX_W-1:0] vertex_index;
    logic              was_new;
    logic              overflow;
  } res_t;

endpackage

// ===== src/tvd_ifs.sv =====
// Valid/ready channel interfaces for vertex input and index result.
// Depends on tvd_pkg for the index width.
`timescale 1ns / 1ps

interface tvd_vtx_if;
  logic               valid;
  logic               ready;
  logic               new_mesh;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] norm_x;
  logic signed [31:0] norm_y;
  logic signed [31:0] norm_z;
  logic signed [31:0] tex_u;
  logic signed [31:0] tex_v;

  modport source (output valid, new_mesh, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                  tex_u, tex_v, input ready);
  modport sink (input valid, new_mesh, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                tex_u, tex_v, output ready);
endinterface

interface tvd_res_if;
  logic                            valid;
  logic                            ready;
  logic [tvd_pkg::VIDX_W-1:0]      vertex_index;
  logic                            was_new;
  logic                            overflow;

  modport source (output valid, vertex_index, was_new, overflow, input ready);
  modport sink (input valid, vertex_index, was_new, overflow, output ready);
endinterface

// ===== src/tvd_ram.sv =====
// Generic single-clock RAM, one write port and one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module tvd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/tvd_ctrl.sv =====
// Controller state machine: accepts vertices, runs the scan, hands off results.
// Depends on tvd_pkg for state, command and status types.
`timescale 1ns / 1ps

module tvd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  tvd_pkg::status_t status_i,
  output tvd_pkg::cmd_t    cmd_o
);

  tvd_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      tvd_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = tvd_pkg::ST_SCAN;
      end
      tvd_pkg::ST_SCAN: begin
        if ((status_i.hit || status_i.miss) && status_i.slot_free) state_d = tvd_pkg::ST_IDLE;
      end
      default: state_d = tvd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    case (state_q)
      tvd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      tvd_pkg::ST_SCAN: begin
        cmd_o.scan   = 1'b1;
        cmd_o.finish = (status_i.hit || status_i.miss) && status_i.slot_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tvd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/tvd_datapath.sv =====
// Datapath: vertex store, scan pointer, per-field tolerance compare, result register.
// Depends on tvd_pkg and tvd_ram.
`timescale 1ns / 1ps

module tvd_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        tol_we_i,
  input  logic [tvd_pkg::TOL_W-1:0]   tol_wdata_i,
  input  logic                        new_mesh_i,
  input  logic [tvd_pkg::ENTRY_W-1:0] vtx_i,
  input  tvd_pkg::cmd_t               cmd_i,
  output tvd_pkg::status_t            status_o,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output tvd_pkg::res_t               res_o
);

  logic [tvd_pkg::TOL_W-1:0]   tol_q;
  logic [tvd_pkg::ENTRY_W-1:0] vtx_q;
  logic [tvd_pkg::CNT_W-1:0]   count_q, count_d;
  logic [tvd_pkg::CNT_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [tvd_pkg::CNT_W-1:0]   cmp_idx_q, cmp_idx_d;
  logic                        cmp_vld_q, cmp_vld_d;
  tvd_pkg::res_t               res_q, res_d;
  logic                        res_vld_q, res_vld_d;

  logic [tvd_pkg::ENTRY_W-1:0] rdata;
  logic                        ram_re, ram_we;
  logic [tvd_pkg::NFIELDS-1:0] near;
  logic                        hit, miss, full;

  tvd_ram #(
    .WIDTH (tvd_pkg::ENTRY_W),
    .DEPTH (tvd_pkg::MAX_VERTICES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[tvd_pkg::IDX_W-1:0]),
    .wdata_i (vtx_q),
    .re_i    (ram_re),
    .raddr_i (rd_ptr_q[tvd_pkg::IDX_W-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    logic signed [tvd_pkg::FIELD_W:0] a;
    logic signed [tvd_pkg::FIELD_W:0] b;
    logic signed [tvd_pkg::FIELD_W:0] diff;
    logic        [tvd_pkg::FIELD_W:0] mag;
    for (int k = 0; k < tvd_pkg::NFIELDS; k++) begin
      a       = {vtx_q[k*tvd_pkg::FIELD_W + tvd_pkg::FIELD_W-1],
                 vtx_q[k*tvd_pkg::FIELD_W +: tvd_pkg::FIELD_W]};
      b       = {rdata[k*tvd_pkg::FIELD_W + tvd_pkg::FIELD_W-1],
                 rdata[k*tvd_pkg::FIELD_W +: tvd_pkg::FIELD_W]};
      diff    = a - b;
      mag     = diff[tvd_pkg::FIELD_W] ? unsigned'(-diff) : unsigned'(diff);
      near[k] = mag < (tvd_pkg::FIELD_W+1)'(tol_q);
    end
  end

  assign hit  = cmp_vld_q && (&near);
  assign miss = !cmp_vld_q && (rd_ptr_q == count_q);
  assign full = (count_q == tvd_pkg::CNT_FULL);

  assign status_o.hit       = hit;
  assign status_o.miss      = miss;
  assign status_o.slot_free = !res_vld_q || res_ready_i;

  assign ram_re = cmd_i.scan && !hit && (rd_ptr_q < count_q);
  assign ram_we = cmd_i.finish && !hit && !full;

  always_comb begin
    count_d   = count_q;
    rd_ptr_d  = rd_ptr_q;
    cmp_idx_d = cmp_idx_q;
    cmp_vld_d = cmp_vld_q;
    res_d     = res_q;
    res_vld_d = res_vld_q && !res_ready_i;
    if (cmd_i.load) begin
      rd_ptr_d  = '0;
      cmp_vld_d = 1'b0;
      if (new_mesh_i) count_d = '0;
    end else if (cmd_i.scan && !hit) begin
      cmp_vld_d = ram_re;
      cmp_idx_d = rd_ptr_q;
      if (ram_re) rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (cmd_i.finish) begin
      res_vld_d = 1'b1;
      if (hit) begin
        res_d.vertex_index = tvd_pkg::VIDX_W'(cmp_idx_q);
        res_d.was_new      = 1'b0;
        res_d.overflow     = 1'b0;
      end else if (full) begin
        res_d.vertex_index = '0;
        res_d.was_new      = 1'b0;
        res_d.overflow     = 1'b1;
      end else begin
        res_d.vertex_index = tvd_pkg::VIDX_W'(count_q);
        res_d.was_new      = 1'b1;
        res_d.overflow     = 1'b0;
        count_d            = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q     <= tvd_pkg::TOL_RESET;
      count_q   <= '0;
      rd_ptr_q  <= '0;
      cmp_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (tol_we_i) tol_q <= tol_wdata_i;
      count_q   <= count_d;
      rd_ptr_q  <= rd_ptr_d;
      cmp_vld_q <= cmp_vld_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) vtx_q <= vtx_i;
    cmp_idx_q <= cmp_idx_d;
    res_q     <= res_d;
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= tvd_pkg::CNT_FULL)
    else $error("vertex count beyond store depth");

  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("store read and write in one cycle");

  a_cmp_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> (cmp_idx_q < count_q))
    else $error("compare of an entry beyond the fill count");

  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> (count_q == tvd_pkg::CNT_W'($past(count_q) + 1'b1)))
    else $error("append did not advance the count");

  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> (!res_vld_q || res_ready_i))
    else $error("result overwritten before transaction");

endmodule

// ===== src/tolerant_vertex_dedup.sv =====
// Top level of the tolerant vertex dedup block: controller, datapath and vertex store.
// Depends on tvd_pkg, tvd_ifs, tvd_ctrl and tvd_datapath.
//
// Usage: each vertex transaction on vtx_i carries eight signed Q16.16 fields and a
// new_mesh flag; each yields exactly one transaction on res_o with the index of the
// first stored vertex whose fields all lie strictly within the tolerance, or the index
// under which the vertex was appended (was_new), or overflow with index 0 when the
// store is full. new_mesh empties the store before the vertex is handled.
// The user writes the tolerance through tol_we_i / tol_wdata_i only while the block
// is idle; the block itself does not enforce this. The scan reads one stored entry
// per cycle, and the next vertex is accepted once the result of the last one is
// registered. One vertex is in work at a time.
// Reset empties the store (fill count to zero, no clearing pass) and sets the tolerance
// to 655 (0.01). A result waits in an output register while the receiver stalls; the
// next vertex is accepted and scanned meanwhile and holds its result until the
// register frees.
`timescale 1ns / 1ps

module tolerant_vertex_dedup (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      tol_we_i,
  input  logic [tvd_pkg::TOL_W-1:0] tol_wdata_i,
  tvd_vtx_if.sink                   vtx_i,
  tvd_res_if.source                 res_o
);

  tvd_pkg::cmd_t    cmd;
  tvd_pkg::status_t status;
  tvd_pkg::res_t    res;
  logic             in_ready;
  logic             res_valid;

  tvd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (vtx_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tvd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tol_we_i    (tol_we_i),
    .tol_wdata_i (tol_wdata_i),
    .new_mesh_i  (vtx_i.new_mesh),
    .vtx_i       ({vtx_i.tex_v, vtx_i.tex_u, vtx_i.norm_z, vtx_i.norm_y,
                   vtx_i.norm_x, vtx_i.pos_z, vtx_i.pos_y, vtx_i.pos_x}),
    .cmd_i       (cmd),
    .status_o    (status),
    .res_valid_o (res_valid),
    .res_ready_i (res_o.ready),
    .res_o       (res)
  );

  assign vtx_i.ready        = in_ready;
  assign res_o.valid        = res_valid;
  assign res_o.vertex_index = res.vertex_index;
  assign res_o.was_new      = res.was_new;
  assign res_o.overflow     = res.overflow;

endmodule
